[sv/sitf_pkg.sv]
// ============================================================================
// sitf_pkg
// Shared types and constants for the scaled integer to IEEE float converter.
// ============================================================================
package sitf_pkg;

   localparam int unsigned RawWidth = 32;
   localparam int unsigned LeadWidth = 5;

   localparam logic [10:0] BiasSingle = 11'd127;
   localparam logic [10:0] BiasDouble = 11'd1023;
   localparam logic [5:0]  MaxWidthSingle = 6'd24;
   localparam logic [5:0]  MaxWidthDouble = 6'd32;
   localparam logic [63:0] SignDouble = 64'h8000_0000_0000_0000;
   localparam logic [63:0] SignSingle = 64'h0000_0000_8000_0000;

   typedef enum logic [1:0] {
      OP_U_SINGLE = 2'd0,
      OP_S_SINGLE = 2'd1,
      OP_U_DOUBLE = 2'd2,
      OP_S_DOUBLE = 2'd3
   } op_type;

   // stage 1 -> stage 2 payload
   typedef struct packed {
      logic                 dbl;
      logic                 neg;
      logic                 err;
      logic [RawWidth:0]    mag;
      logic signed [12:0]   exp_base;
   } mag_type;

   // stage 2 -> stage 3 payload
   typedef struct packed {
      logic                 dbl;
      logic                 neg;
      logic                 err;
      logic                 zero;
      logic [RawWidth:0]    mag;
      logic [LeadWidth:0]   lead;
      logic signed [12:0]   exp_base;
   } lead_type;

endpackage

[sv/sitf_front.sv]
// ============================================================================
// sitf_front
// Stage 1: range check, field masking, sign extraction and magnitude.
// ============================================================================
module sitf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [1:0]            operation,
   input  logic [31:0]           raw_code,
   input  logic [5:0]            field_width,
   input  logic signed [10:0]    lsb_exponent,
   output logic                  out_valid,
   output sitf_pkg::mag_type     out_data
);
   import sitf_pkg::*;

   logic              valid_ff;
   mag_type           data_ff;
   mag_type           data_in;
   logic              dbl;
   logic              sgn;
   logic [10:0]       bias;
   logic signed [12:0] lsb_ext;
   logic signed [12:0] top;
   logic [32:0]       full;
   logic [32:0]       f;
   logic              msb;

   always_comb begin
      dbl = operation[1];
      sgn = operation[0];
      bias = dbl ? BiasDouble : BiasSingle;
      lsb_ext = 13'(lsb_exponent);
      top = lsb_ext + $signed({7'd0, field_width});
      full = 33'd1 << field_width;
      f = {1'b0, raw_code} & (full - 33'd1);
      msb = (field_width != 6'd0) && ((f >> (field_width - 6'd1)) & 33'd1) != 33'd0;
      data_in.dbl = dbl;
      data_in.neg = sgn && msb;
      data_in.err = (field_width > (dbl ? MaxWidthDouble : MaxWidthSingle))
         || (lsb_ext < -$signed({2'b00, bias}))
         || (top > $signed({2'b00, bias}));
      data_in.mag = data_in.neg ? (full - f) : f;
      data_in.exp_base = $signed({2'b00, bias}) + lsb_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

[sv/sitf_lead.sv]
// ============================================================================
// sitf_lead
// Stage 2: leading-one detection on the magnitude.
// ============================================================================
module sitf_lead (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sitf_pkg::mag_type     in_data,
   output logic                  out_valid,
   output sitf_pkg::lead_type    out_data
);
   import sitf_pkg::*;

   logic     valid_ff;
   lead_type data_ff;
   lead_type data_in;

   always_comb begin
      data_in.dbl = in_data.dbl;
      data_in.neg = in_data.neg;
      data_in.err = in_data.err;
      data_in.mag = in_data.mag;
      data_in.exp_base = in_data.exp_base;
      data_in.zero = (in_data.mag == '0);
      data_in.lead = '0;
      if (in_data.mag[32]) begin
         data_in.lead = 6'd32;
      end else begin
         for (int i = 0; i < 32; i++) begin
            if (in_data.mag[i]) begin
               data_in.lead = 6'(i);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

[sv/sitf_pack.sv]
// ============================================================================
// sitf_pack
// Stage 3: exponent, significand alignment and IEEE packing.
// ============================================================================
module sitf_pack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sitf_pkg::lead_type    in_data,
   output logic                  out_valid,
   output logic [63:0]           out_bits,
   output logic                  out_error
);
   import sitf_pkg::*;

   logic               valid_ff;
   logic [63:0]        bits_ff;
   logic [63:0]        bits_in;
   logic               error_ff;
   logic signed [12:0] be;
   logic [63:0]        frac;
   logic [63:0]        mant;
   logic [5:0]         fracbits;

   always_comb begin
      fracbits = in_data.dbl ? 6'd52 : 6'd23;
      be = in_data.exp_base + $signed({7'd0, in_data.lead});
      mant = {31'd0, in_data.mag} ^ (64'd1 << in_data.lead);
      frac = mant << (fracbits - in_data.lead);
      bits_in = '0;
      if (!in_data.err && !in_data.zero) begin
         if (be <= 13'sd0) begin
            bits_in = {31'd0, in_data.mag} << (fracbits - 6'd1);
         end else begin
            bits_in = ({51'd0, be[12:0]} << fracbits) | frac;
         end
         if (in_data.neg) begin
            bits_in = bits_in | (in_data.dbl ? SignDouble : SignSingle);
         end
         if (!in_data.dbl) begin
            bits_in[63:32] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      bits_ff <= bits_in;
      error_ff <= in_data.err;
   end

   assign out_valid = valid_ff;
   assign out_bits = bits_ff;
   assign out_error = error_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && error_ff |-> bits_ff == 64'd0)
      else $error("error item carries nonzero bits");
   a_single_upper: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_data.dbl |=> bits_ff[63:32] == 32'd0)
      else $error("single result has upper bits set");
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_data.zero |=> bits_ff == 64'd0)
      else $error("zero field not +0.0");
`endif
endmodule

[sv/scaled_int_to_ieee_float.sv]
// ============================================================================
// scaled_int_to_ieee_float
// Converts a scaled integer field into an exact IEEE single or double pattern.
// ============================================================================
// Three-stage pipeline (range check and magnitude, leading-one search,
// packing). busy is always low: an item is taken every cycle. An accepted
// item is registered in the front, lead and pack stages in that order, and
// rsp_valid comes from the pack stage register. The receiver cannot stall;
// results must be taken on the cycle they appear.
module scaled_int_to_ieee_float (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [31:0]        req_raw_code,
   input  logic [5:0]         req_field_width,
   input  logic signed [10:0] req_lsb_exponent,
   output logic               rsp_valid,
   output logic [63:0]        rsp_float_bits,
   output logic               rsp_range_error
);
   import sitf_pkg::*;

   logic     v1;
   logic     v2;
   mag_type  d1;
   lead_type d2;

   assign busy = 1'b0;

   sitf_front u_front (
      .clock(clock), .reset(reset), .in_valid(start && !busy),
      .operation(req_operation), .raw_code(req_raw_code),
      .field_width(req_field_width), .lsb_exponent(req_lsb_exponent),
      .out_valid(v1), .out_data(d1)
   );

   sitf_lead u_lead (
      .clock(clock), .reset(reset), .in_valid(v1), .in_data(d1),
      .out_valid(v2), .out_data(d2)
   );

   sitf_pack u_pack (
      .clock(clock), .reset(reset), .in_valid(v2), .in_data(d2),
      .out_valid(rsp_valid), .out_bits(rsp_float_bits),
      .out_error(rsp_range_error)
   );
endmodule

[tb/scaled_int_to_ieee_float_test.sv]
// ============================================================================
// scaled_int_to_ieee_float_test
// Self-checking bench: directed corner items, then random conversions with
// random start gaps; every result is compared with a built-in predictor.
// ============================================================================
module scaled_int_to_ieee_float_test;
   import sitf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] float_bits;
      logic        range_error;
   } conv_result;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic [31:0]        req_raw_code;
   logic [5:0]         req_field_width;
   logic signed [10:0] req_lsb_exponent;
   logic               rsp_valid;
   logic [63:0]        rsp_float_bits;
   logic               rsp_range_error;

   conv_result pending_floats[$];
   int         error_count = 0;
   int         item_count = 0;
   int         result_count = 0;
   int         range_error_count = 0;
   longint     cycle_count = 0;

   scaled_int_to_ieee_float u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_raw_code(req_raw_code),
      .req_field_width(req_field_width),
      .req_lsb_exponent(req_lsb_exponent),
      .rsp_valid(rsp_valid),
      .rsp_float_bits(rsp_float_bits),
      .rsp_range_error(rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic conv_result convert_scaled(op_type op, logic [31:0] code,
                                                 logic [5:0] width,
                                                 logic signed [10:0] lsb);
      conv_result r;
      logic        dbl;
      logic        sgn;
      int          bias;
      int          maxw;
      int          fracbits;
      logic [32:0] full;
      logic [32:0] f;
      logic [32:0] mag;
      logic        neg;
      int          lead;
      int          be;
      logic [63:0] bits;
      dbl = (op == OP_U_DOUBLE) || (op == OP_S_DOUBLE);
      sgn = (op == OP_S_SINGLE) || (op == OP_S_DOUBLE);
      bias = dbl ? 1023 : 127;
      maxw = dbl ? 32 : 24;
      fracbits = dbl ? 52 : 23;
      r.float_bits = '0;
      r.range_error = 1'b0;
      if (int'(width) > maxw || int'(lsb) < -bias || int'(lsb) + int'(width) > bias) begin
         r.range_error = 1'b1;
         return r;
      end
      full = 33'd1 << width;
      f = {1'b0, code} & (full - 33'd1);
      neg = sgn && width != 0 && f[width - 1];
      mag = neg ? full - f : f;
      bits = '0;
      if (mag != 0) begin
         lead = 0;
         for (int i = 0; i < 33; i++)
            if (mag[i]) lead = i;
         be = bias + int'(lsb) + lead;
         if (be <= 0) begin
            bits = 64'(mag) << (fracbits - 1);
         end else begin
            bits = (64'(be) << fracbits)
                 | (64'(mag ^ (33'd1 << lead)) << (fracbits - lead));
         end
         if (neg) bits |= dbl ? SignDouble : SignSingle;
      end
      if (!dbl) bits[63:32] = '0;
      r.float_bits = bits;
      return r;
   endfunction

   task automatic send_item(op_type op, logic [31:0] code, logic [5:0] width,
                            logic signed [10:0] lsb, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_raw_code <= code;
      req_field_width <= width;
      req_lsb_exponent <= lsb;
      do @(posedge clock); while (busy);
      pending_floats.push_back(convert_scaled(op, code, width, lsb));
      item_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         conv_result want;
         if (pending_floats.size() == 0) begin
            $error("unexpected result float_bits=%h", rsp_float_bits);
            error_count++;
         end else begin
            want = pending_floats.pop_front();
            result_count++;
            if (rsp_range_error) range_error_count++;
            if (rsp_float_bits !== want.float_bits) begin
               $error("float_bits expected %h actual %h", want.float_bits, rsp_float_bits);
               error_count++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error expected %b actual %b", want.range_error,
                      rsp_range_error);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count > 200000);
      $display("status: fail");
      $finish;
   end

   task automatic test_corners();
      for (int k = 0; k < 4; k++) begin
         op_type op;
         op = op_type'(k);
         send_item(op, 32'h0, 6'd0, 11'sd0, 0);
         send_item(op, 32'hFFFF_FFFF, k[1] ? 6'd32 : 6'd24, 11'sd0, 0);
         send_item(op, 32'h1, 6'd1, k[1] ? -11'sd1023 : -11'sd127, 1);
         send_item(op, 32'h8000_0000, 6'd32, -11'sd5, 0);
         send_item(op, 32'h0080_0000, 6'd24, 11'sd103, 0);
         send_item(op, 32'hDEAD_BEEF, k[1] ? 6'd33 : 6'd25, 11'sd0, 2);
      end
      send_item(OP_S_DOUBLE, 32'h1, 6'd1, -11'sd1023, 0);
      send_item(OP_U_DOUBLE, 32'h5, 6'd3, 11'sd1020, 0);
      send_item(OP_U_DOUBLE, 32'h5, 6'd4, 11'sd1020, 0);
      send_item(OP_S_SINGLE, 32'h1, 6'd1, -11'sd128, 0);
      send_item(OP_U_SINGLE, 32'hFFFF_FF00, 6'd8, 11'sd0, 0);
      send_item(OP_U_DOUBLE, 32'h3, 6'd63, 11'sh400, 0);
   endtask

   task automatic test_random();
      for (int n = 0; n < 600; n++) begin
         op_type      op;
         logic [5:0]  width;
         int          lsb;
         int          gap;
         op = op_type'($urandom_range(0, 3));
         if ($urandom_range(0, 9) == 0) width = 6'($urandom);
         else width = 6'($urandom_range(0, op[1] ? 32 : 24));
         case ($urandom_range(0, 5))
            0: lsb = $urandom_range(0, 2047) - 1024;
            1: lsb = (op[1] ? -1023 : -127) + $urandom_range(0, 2);
            2: lsb = (op[1] ? 1023 : 127) - int'(width) + $urandom_range(0, 1);
            default: lsb = $urandom_range(0, 60) - 30;
         endcase
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
         send_item(op, $urandom, width, 11'(lsb), (n / 100) % 2 ? 0 : gap);
      end
   endtask

   initial begin
      int drain;
      reset = 1'b1;
      start = 1'b0;
      req_operation = '0;
      req_raw_code = '0;
      req_field_width = '0;
      req_lsb_exponent = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random();
      start <= 1'b0;
      drain = 0;
      while (pending_floats.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (pending_floats.size() != 0) begin
         $error("%0d results missing", pending_floats.size());
         error_count++;
      end
      $display("sent %0d items, checked %0d results, %0d with range error",
               item_count, result_count, range_error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
